@@ hw/rtl/cpte_pkg.sv @@
// shared types, widths and codes for the triangle edge nearest point pipeline
package cpte_pkg;

  localparam int COORD_BITS = 24;
  // coordinate difference, one bit wider than a coordinate
  localparam int DIFF_W     = COORD_BITS + 1;
  // product of two differences
  localparam int PROD_W     = 2 * DIFF_W;
  // dot product and squared length
  localparam int DOT_W      = PROD_W + 1;
  // divider remainder, holds 2r + t below 3L
  localparam int REM_W      = 2 * COORD_BITS + 4;
  // depth of the segment pipeline, from segment inputs to registered candidate
  localparam int SEG_LAT    = DIFF_W + 5;
  // span from the accepting edge to the edge that samples done high
  localparam int PIPE_LAT   = SEG_LAT + 5;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    SEL_START,
    SEL_END,
    SEL_DIV
  } cand_sel_t;

  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t query_x;
    coord_t query_y;
  } cpte_in_t;

  typedef struct packed {
    coord_t nearest_x;
    coord_t nearest_y;
  } cpte_out_t;

endpackage

@@ hw/rtl/closest_point_on_triangle_edges.sv @@
// nearest point on a triangle boundary: from accept to done the path runs through an
// input register, then a segment pipeline of COORD_BITS+6 stages
// with a one-bit-per-stage divider, then distance, square, sum and select stages
// throughput one transaction per cycle; busy stays low and results are never held
// synchronous active-high reset clears only the valid bits; data registers are not reset
module closest_point_on_triangle_edges (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cpte_pkg::cpte_in_t  item,
  output logic                busy,
  output logic                done,
  output cpte_pkg::cpte_out_t result
);
  import cpte_pkg::*;

  localparam int SQ_W   = 2 * COORD_BITS + 2;
  localparam int DIST_W = SQ_W + 1;

  assign busy = 1'b0;

  // input register
  logic     in_v;
  cpte_in_t in_q;

  always_ff @(posedge clk) begin
    if (rst) in_v <= 1'b0;
    else     in_v <= start && !busy;
    in_q <= item;
  end

  // query point delay matching the segment pipeline
  coord_t p_dly [0:SEG_LAT-1][2];

  always_ff @(posedge clk) begin
    p_dly[0][0] <= in_q.query_x;
    p_dly[0][1] <= in_q.query_y;
    for (int k = 1; k < SEG_LAT; k++) begin
      p_dly[k][0] <= p_dly[k-1][0];
      p_dly[k][1] <= p_dly[k-1][1];
    end
  end

  // three segment units: ab, bc, ca
  logic   seg_v;
  coord_t cand [3][2];

  cpte_seg u_ab (
    .clk, .rst, .valid_in(in_v),
    .sx(in_q.vertex_a_x), .sy(in_q.vertex_a_y),
    .ex(in_q.vertex_b_x), .ey(in_q.vertex_b_y),
    .px(in_q.query_x), .py(in_q.query_y),
    .valid_out(seg_v), .cx(cand[0][0]), .cy(cand[0][1])
  );

  cpte_seg u_bc (
    .clk, .rst, .valid_in(in_v),
    .sx(in_q.vertex_b_x), .sy(in_q.vertex_b_y),
    .ex(in_q.vertex_c_x), .ey(in_q.vertex_c_y),
    .px(in_q.query_x), .py(in_q.query_y),
    .valid_out(), .cx(cand[1][0]), .cy(cand[1][1])
  );

  cpte_seg u_ca (
    .clk, .rst, .valid_in(in_v),
    .sx(in_q.vertex_c_x), .sy(in_q.vertex_c_y),
    .ex(in_q.vertex_a_x), .ey(in_q.vertex_a_y),
    .px(in_q.query_x), .py(in_q.query_y),
    .valid_out(), .cx(cand[2][0]), .cy(cand[2][1])
  );

  // offset from query point
  logic                        v1, v2, v3;
  logic signed [COORD_BITS:0]  u1 [3][2];
  logic signed [SQ_W-1:0]      sq2 [3][2];
  logic signed [DIST_W-1:0]    dist3 [3];
  coord_t                      c1 [3][2];
  coord_t                      c2 [3][2];
  coord_t                      c3 [3][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= seg_v;
      v2 <= v1;
      v3 <= v2;
    end
    for (int s = 0; s < 3; s++) begin
      for (int a = 0; a < 2; a++) begin
        u1[s][a]  <= (COORD_BITS+1)'(cand[s][a]) - (COORD_BITS+1)'(p_dly[SEG_LAT-1][a]);
        c1[s][a]  <= cand[s][a];
        sq2[s][a] <= u1[s][a] * u1[s][a];
        c2[s][a]  <= c1[s][a];
        c3[s][a]  <= c2[s][a];
      end
      dist3[s] <= DIST_W'(sq2[s][0]) + DIST_W'(sq2[s][1]);
    end
  end

  // pick the nearest, ab first, then bc
  cpte_out_t pick;

  always_comb begin
    if (dist3[0] <= dist3[1] && dist3[0] <= dist3[2]) begin
      pick.nearest_x = c3[0][0];
      pick.nearest_y = c3[0][1];
    end else if (dist3[1] <= dist3[2]) begin
      pick.nearest_x = c3[1][0];
      pick.nearest_y = c3[1][1];
    end else begin
      pick.nearest_x = c3[2][0];
      pick.nearest_y = c3[2][1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v3;
    result <= pick;
  end

endmodule

@@ hw/rtl/cpte_seg.sv @@
// clamped projection of a point onto one segment, pipelined with a bit-per-stage divider
module cpte_seg (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  cpte_pkg::coord_t  sx,
  input  cpte_pkg::coord_t  sy,
  input  cpte_pkg::coord_t  ex,
  input  cpte_pkg::coord_t  ey,
  input  cpte_pkg::coord_t  px,
  input  cpte_pkg::coord_t  py,
  output logic              valid_out,
  output cpte_pkg::coord_t  cx,
  output cpte_pkg::coord_t  cy
);
  import cpte_pkg::*;

  // stage 1: differences
  logic                     v1;
  logic signed [DIFF_W-1:0] dx1, dy1, wx1, wy1;
  coord_t                   s1x, s1y, e1x, e1y;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= valid_in;
    dx1 <= DIFF_W'(ex) - DIFF_W'(sx);
    dy1 <= DIFF_W'(ey) - DIFF_W'(sy);
    wx1 <= DIFF_W'(px) - DIFF_W'(sx);
    wy1 <= DIFF_W'(py) - DIFF_W'(sy);
    s1x <= sx;
    s1y <= sy;
    e1x <= ex;
    e1y <= ey;
  end

  // stage 2: products
  logic                     v2;
  logic signed [PROD_W-1:0] pxx, pyy, lxx, lyy;
  logic signed [DIFF_W-1:0] dx2, dy2;
  coord_t                   s2x, s2y, e2x, e2y;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    pxx <= wx1 * dx1;
    pyy <= wy1 * dy1;
    lxx <= dx1 * dx1;
    lyy <= dy1 * dy1;
    dx2 <= dx1;
    dy2 <= dy1;
    s2x <= s1x;
    s2y <= s1y;
    e2x <= e1x;
    e2y <= e1y;
  end

  // stage 3: dot product and squared length
  logic                     v3;
  logic signed [DOT_W-1:0]  t3, l3;
  logic signed [DIFF_W-1:0] dx3, dy3;
  coord_t                   s3x, s3y, e3x, e3y;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    t3  <= DOT_W'(pxx) + DOT_W'(pyy);
    l3  <= DOT_W'(lxx) + DOT_W'(lyy);
    dx3 <= dx2;
    dy3 <= dy2;
    s3x <= s2x;
    s3y <= s2y;
    e3x <= e2x;
    e3y <= e2y;
  end

  // divider pipeline: entry 0 is set up from stage 3, entry j retires one bit of |d|
  logic                    dv   [0:DIFF_W];
  cand_sel_t               dsel [0:DIFF_W];
  logic [REM_W-1:0]        dt   [0:DIFF_W];
  logic [REM_W-1:0]        dl   [0:DIFF_W];
  coord_t                  ds   [0:DIFF_W][2];
  coord_t                  de   [0:DIFF_W][2];
  logic                    dneg [0:DIFF_W][2];
  logic [DIFF_W-1:0]       dmag [0:DIFF_W][2];
  logic [REM_W-1:0]        drem [0:DIFF_W][2];
  logic [DIFF_W-1:0]       dquo [0:DIFF_W][2];

  cand_sel_t               sel3;
  logic signed [DIFF_W-1:0] d3 [2];

  // pick start, end or interior point
  always_comb begin
    d3[0] = dx3;
    d3[1] = dy3;
    if (t3[DOT_W-1])          sel3 = SEL_START;
    else if (t3 > l3)         sel3 = SEL_END;
    else if (l3 == '0)        sel3 = SEL_START;
    else                      sel3 = SEL_DIV;
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= v3;
    dsel[0] <= sel3;
    dt[0]   <= REM_W'($unsigned(t3));
    dl[0]   <= REM_W'($unsigned(l3));
    ds[0][0] <= s3x;
    ds[0][1] <= s3y;
    de[0][0] <= e3x;
    de[0][1] <= e3y;
    for (int a = 0; a < 2; a++) begin
      dneg[0][a] <= d3[a][DIFF_W-1];
      dmag[0][a] <= d3[a][DIFF_W-1] ? DIFF_W'(-d3[a]) : DIFF_W'(d3[a]);
      drem[0][a] <= '0;
      dquo[0][a] <= '0;
    end
  end

  for (genvar j = 1; j <= DIFF_W; j++) begin : g_div
    // sideband travels with the partial quotient
    always_ff @(posedge clk) begin
      if (rst) dv[j] <= 1'b0;
      else     dv[j] <= dv[j-1];
      dsel[j] <= dsel[j-1];
      dt[j]   <= dt[j-1];
      dl[j]   <= dl[j-1];
      ds[j][0] <= ds[j-1][0];
      ds[j][1] <= ds[j-1][1];
      de[j][0] <= de[j-1][0];
      de[j][1] <= de[j-1][1];
    end

    for (genvar a = 0; a < 2; a++) begin : g_ax
      logic [REM_W-1:0]  acc;
      logic [REM_W-1:0]  l2;
      logic [REM_W-1:0]  rem_next;
      logic [DIFF_W-1:0] quo_next;

      // r' = 2r + bit*t, then take off L or 2L
      always_comb begin
        l2  = {dl[j-1][REM_W-2:0], 1'b0};
        acc = {drem[j-1][a][REM_W-2:0], 1'b0}
            + (dmag[j-1][a][DIFF_W-1] ? dt[j-1] : '0);
        if (acc >= l2) begin
          rem_next = acc - l2;
          quo_next = {dquo[j-1][a][DIFF_W-2:0], 1'b0} + DIFF_W'(2);
        end else if (acc >= dl[j-1]) begin
          rem_next = acc - dl[j-1];
          quo_next = {dquo[j-1][a][DIFF_W-2:0], 1'b1};
        end else begin
          rem_next = acc;
          quo_next = {dquo[j-1][a][DIFF_W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        dneg[j][a] <= dneg[j-1][a];
        dmag[j][a] <= {dmag[j-1][a][DIFF_W-2:0], 1'b0};
        drem[j][a] <= rem_next;
        dquo[j][a] <= quo_next;
      end
    end
  end

  // final candidate
  logic signed [COORD_BITS+1:0] off  [2];
  coord_t                       cand [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      off[a] = dneg[DIFF_W][a] ? -$signed({1'b0, dquo[DIFF_W][a]})
                               :  $signed({1'b0, dquo[DIFF_W][a]});
      unique case (dsel[DIFF_W])
        SEL_START: cand[a] = ds[DIFF_W][a];
        SEL_END:   cand[a] = de[DIFF_W][a];
        SEL_DIV:   cand[a] = COORD_BITS'((COORD_BITS+2)'(ds[DIFF_W][a]) + off[a]);
        default:   cand[a] = ds[DIFF_W][a];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else     valid_out <= dv[DIFF_W];
    cx <= cand[0];
    cy <= cand[1];
  end

endmodule

@@ hw/rtl/cpte_checker.sv @@
// port-level checks for the triangle edge nearest point block, bound to the top level
module cpte_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input cpte_pkg::cpte_out_t result
);
  import cpte_pkg::*;

  // never back-pressures
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every accepted transaction is followed by done
  a_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("result missing after accept");

  // no result without a transaction
  a_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, PIPE_LAT))
    else $error("result without accept");

  // result is fully defined when strobed
  a_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(result))
    else $error("unknown result");

endmodule

bind closest_point_on_triangle_edges cpte_checker u_cpte_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
